@@ rtl/sfs_pkg.sv @@
// Shared types, constants and helpers of the sprite frame sequencer.
package sfs_pkg;

	localparam int MAX_FRAMES = 1024;

	localparam int IDX_W   = 10;
	localparam int LEN_W   = IDX_W + 1;
	localparam int SHEET_W = 11;
	localparam int TIME_W  = 32;
	localparam int SPEED_W = 16;
	localparam int PROD_W  = TIME_W + SPEED_W;
	localparam int DIM_W   = 12;
	localparam int POS_W   = 16;
	localparam int ACC_W   = SHEET_W + DIM_W;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_SHEET_COLS   = 3'd2,
		CFG_FIRST_FRAME  = 3'd3,
		CFG_CLIP_LENGTH  = 3'd4,
		CFG_FRAME_PERIOD = 3'd5,
		CFG_LOOP_ENABLE  = 3'd6,
		CFG_PLAY_SPEED   = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_UPD,
		ST_SHEET,
		ST_WAIT,
		ST_OUT
	} seq_state_t;

	typedef enum logic [1:0] {
		SP_IDLE,
		SP_DIV,
		SP_MUL
	} pos_state_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} sheet_pos_t;

	// clamp a pixel coordinate to the 16-bit range
	function automatic logic [POS_W-1:0] sat_pos(input logic [ACC_W-1:0] v);
		logic [POS_W-1:0] r;
		r = (|v[ACC_W-1:POS_W]) ? {POS_W{1'b1}} : v[POS_W-1:0];
		return r;
	endfunction

endpackage

@@ rtl/sfs_sheet_pos.sv @@
// Bit-serial sheet position unit: frame number to pixel origin on the sheet.
module sfs_sheet_pos import sfs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SHEET_W-1:0]  sheet_frame,
	input  logic [SHEET_W-1:0]  columns,
	input  logic [DIM_W-1:0]    tile_w,
	input  logic [DIM_W-1:0]    tile_h,
	output logic                done,
	output sheet_pos_t          pos
);

	localparam int CNT_W = $clog2(SHEET_W);

	pos_state_t         state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               cnt_last;
	logic               done_q;

	logic [SHEET_W-1:0] dvd_q;
	logic [SHEET_W-1:0] rem_q;
	logic [ACC_W-1:0]   accx_q;
	logic [ACC_W-1:0]   accy_q;

	logic [SHEET_W:0]   trial;
	logic [SHEET_W:0]   diff;
	logic               ge;

	assign cnt_last = (cnt_q == CNT_W'(SHEET_W - 1));

	// restoring division step: one quotient bit per cycle
	assign trial = {rem_q, dvd_q[SHEET_W-1]};
	assign diff  = trial - {1'b0, columns};
	assign ge    = (trial >= {1'b0, columns});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SP_IDLE: begin
				if (start) state_d = SP_DIV;
			end
			SP_DIV: begin
				if (cnt_last) state_d = SP_MUL;
			end
			SP_MUL: begin
				if (cnt_last) state_d = SP_IDLE;
			end
			default: state_d = SP_IDLE;
		endcase
	end

	always_comb begin
		done  = done_q;
		pos.x = sat_pos(accx_q);
		pos.y = sat_pos(accy_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SP_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SP_MUL) && cnt_last;
			if (state_q == SP_IDLE || cnt_last) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
		end
	end

	// row bits leave the divider MSB first, so y builds up by Horner's rule;
	// x follows once the column (the remainder) is known
	always_ff @(posedge clk) begin
		unique case (state_q)
			SP_IDLE: begin
				if (start) begin
					dvd_q  <= sheet_frame;
					rem_q  <= '0;
					accx_q <= '0;
					accy_q <= '0;
				end
			end
			SP_DIV: begin
				rem_q  <= ge ? diff[SHEET_W-1:0] : trial[SHEET_W-1:0];
				dvd_q  <= {dvd_q[SHEET_W-2:0], ge};
				accy_q <= {accy_q[ACC_W-2:0], 1'b0}
					+ (ge ? ACC_W'(tile_h) : '0);
			end
			SP_MUL: begin
				rem_q  <= {rem_q[SHEET_W-2:0], 1'b0};
				accx_q <= {accx_q[ACC_W-2:0], 1'b0}
					+ (rem_q[SHEET_W-1] ? ACC_W'(tile_w) : '0);
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule

@@ rtl/sprite_frame_sequencer_top.sv @@
// Top level of the sprite frame sequencer: registers, tick sequencer and result stage.
// Sprite-sheet frame sequencer for one grid clip. Each advancing tick adds
// delta_time * play_speed (Q16.16 times Q8.8, truncated, saturated to 32 bits)
// to the elapsed time, takes out every whole frame_period and moves the clip
// index on by that many frames (wrapping in loop mode, finishing on the last
// frame in one-shot mode). Every tick gives one result: the sheet pixel
// origin of the current frame, the index, the finished flag and a one-tick
// end-of-clip pulse. The multiplies and divides are bit serial. An advancing
// tick runs the speed multiply (one speed bit a cycle), the add, the period
// divide (one quotient bit a cycle, with the frame-count reduction folded in),
// the index update, the start of the sheet unit, the row divide and column
// multiply in the sheet unit with its done register, and the result load. A
// restart, hold or finished tick skips the timing work and goes straight to
// the sheet unit. The next tick can be taken in the cycle after the load.
// One tick is worked on at a time; the input is stalled until the result has
// been loaded into the output register, which then waits for its transfer
// while the next tick is taken. Registers must be written only while idle;
// the block itself does not enforce this.
module sprite_frame_sequencer_top import sfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// tick input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TIME_W-1:0]     delta_time,
	input  logic                  restart,
	input  logic                  hold,
	// result output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [POS_W-1:0]      sheet_x,
	output logic [POS_W-1:0]      sheet_y,
	output logic [IDX_W-1:0]      frame_number,
	output logic                  end_pulse,
	output logic                  done_res
);

	localparam int CNT_W = 6;

	// configuration registers
	logic [DIM_W-1:0]   tile_w_q;
	logic [DIM_W-1:0]   tile_h_q;
	logic [SHEET_W-1:0] sheet_columns_q;
	logic [IDX_W-1:0]   first_frame_q;
	logic [LEN_W-1:0]   clip_length_q;
	logic [TIME_W-1:0]  frame_period_q;
	logic               loop_enable_q;
	logic [SPEED_W-1:0] play_speed_q;

	// clip state
	logic [IDX_W-1:0]   index_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic               finished_q;
	logic               pulse_q;

	// sequencer
	seq_state_t         state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               in_xfer;
	logic               out_load;
	logic               sheet_start;
	logic               sheet_done;
	sheet_pos_t         sheet_pos;

	// serial datapath
	logic [TIME_W-1:0]  delta_q;
	logic [PROD_W-1:0]  prod_q;
	logic [IDX_W-1:0]   ish_q;
	logic [IDX_W-1:0]   imod_q;
	logic [TIME_W:0]    dvd_q;
	logic [TIME_W-1:0]  rem_q;
	logic [IDX_W-1:0]   smod_q;

	// result register
	logic               out_valid_q;
	logic [POS_W-1:0]   out_x_q;
	logic [POS_W-1:0]   out_y_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_jf_q;
	logic               out_done_q;

	// effective register values (zero treated as one, length clamped)
	logic [LEN_W-1:0]   len_eff;
	logic [TIME_W-1:0]  period_eff;
	logic [SHEET_W-1:0] cols_eff;

	assign period_eff = (frame_period_q == '0) ? TIME_W'(1) : frame_period_q;
	assign cols_eff   = (sheet_columns_q == '0) ? SHEET_W'(1) : sheet_columns_q;

	always_comb begin
		if (clip_length_q == '0) len_eff = LEN_W'(1);
		else if (clip_length_q > LEN_W'(MAX_FRAMES)) len_eff = LEN_W'(MAX_FRAMES);
		else len_eff = clip_length_q;
	end

	// multiply step: add delta into the top half, shift right
	logic [TIME_W:0]    mul_sum;
	assign mul_sum = {1'b0, prod_q[PROD_W-1:SPEED_W]}
		+ (prod_q[0] ? {1'b0, delta_q} : '0);

	// index mod length, one index bit a cycle during the multiply
	logic [LEN_W-1:0]   imod_t;
	logic [LEN_W-1:0]   imod_d;
	assign imod_t = {imod_q, ish_q[IDX_W-1]};
	assign imod_d = (imod_t >= len_eff) ? imod_t - len_eff : imod_t;

	// scaled delta plus elapsed time, 33 bits exact
	logic [TIME_W-1:0]  scaled;
	logic [TIME_W:0]    total;
	assign scaled = (|prod_q[PROD_W-1:TIME_W+8]) ? {TIME_W{1'b1}} : prod_q[TIME_W+7:8];
	assign total  = {1'b0, elapsed_q} + {1'b0, scaled};

	// period divide step; the quotient bits also feed the steps-mod-length
	logic [TIME_W:0]    div_t;
	logic [TIME_W:0]    div_diff;
	logic               div_ge;
	logic [LEN_W-1:0]   smod_t;
	logic [LEN_W-1:0]   smod_d;
	assign div_t    = {rem_q, dvd_q[TIME_W]};
	assign div_diff = div_t - {1'b0, period_eff};
	assign div_ge   = (div_t >= {1'b0, period_eff});
	assign smod_t   = {smod_q, div_ge};
	assign smod_d   = (smod_t >= len_eff) ? smod_t - len_eff : smod_t;

	// index update
	logic [LEN_W-1:0]   wrap_sum;
	logic [LEN_W-1:0]   wrap_idx;
	logic [LEN_W-1:0]   len_m1;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   remaining;
	logic               overrun;
	logic               any_steps;
	assign wrap_sum  = {1'b0, imod_q} + {1'b0, smod_q};
	assign wrap_idx  = (wrap_sum >= len_eff) ? wrap_sum - len_eff : wrap_sum;
	assign len_m1    = len_eff - 1'b1;
	assign last_idx  = len_m1[IDX_W-1:0];
	assign remaining = (index_q < last_idx) ? last_idx - index_q : '0;
	assign overrun   = (|dvd_q[TIME_W:IDX_W]) || (dvd_q[IDX_W-1:0] > remaining);
	assign any_steps = |dvd_q;

	logic [SHEET_W-1:0] sheet_frame;
	assign sheet_frame = {1'b0, first_frame_q} + {1'b0, index_q};

	assign in_xfer = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (restart || hold || finished_q) state_d = ST_SHEET;
					else state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == CNT_W'(SPEED_W - 1)) state_d = ST_ADD;
			end
			ST_ADD:   state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(TIME_W)) state_d = ST_UPD;
			end
			ST_UPD:   state_d = ST_SHEET;
			ST_SHEET: state_d = ST_WAIT;
			ST_WAIT: begin
				if (sheet_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		sheet_start = (state_q == ST_SHEET);
		out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_w_q        <= DIM_W'(16);
			tile_h_q        <= DIM_W'(16);
			sheet_columns_q <= SHEET_W'(1);
			first_frame_q   <= '0;
			clip_length_q   <= LEN_W'(1);
			frame_period_q  <= TIME_W'(65536);
			loop_enable_q   <= 1'b1;
			play_speed_q    <= SPEED_W'(256);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  tile_w_q        <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT: tile_h_q        <= cfg_data[DIM_W-1:0];
				CFG_SHEET_COLS:   sheet_columns_q <= cfg_data[SHEET_W-1:0];
				CFG_FIRST_FRAME:  first_frame_q   <= cfg_data[IDX_W-1:0];
				CFG_CLIP_LENGTH:  clip_length_q   <= cfg_data[LEN_W-1:0];
				CFG_FRAME_PERIOD: frame_period_q  <= cfg_data[TIME_W-1:0];
				CFG_LOOP_ENABLE:  loop_enable_q   <= cfg_data[0];
				CFG_PLAY_SPEED:   play_speed_q    <= cfg_data[SPEED_W-1:0];
				default:          loop_enable_q   <= loop_enable_q;
			endcase
		end
	end

	// clip state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q    <= '0;
			elapsed_q  <= '0;
			finished_q <= 1'b0;
			pulse_q    <= 1'b0;
		end else begin
			if (in_xfer) begin
				pulse_q <= 1'b0;
				if (restart) begin
					index_q    <= '0;
					elapsed_q  <= '0;
					finished_q <= 1'b0;
				end
			end else if (state_q == ST_UPD) begin
				elapsed_q <= rem_q;
				if (any_steps) begin
					if (loop_enable_q) begin
						index_q <= wrap_idx[IDX_W-1:0];
					end else if (overrun) begin
						// ran past the last frame: park there and finish
						index_q    <= last_idx;
						elapsed_q  <= '0;
						finished_q <= 1'b1;
						pulse_q    <= 1'b1;
					end else begin
						index_q <= index_q + dvd_q[IDX_W-1:0];
					end
				end
			end
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			delta_q <= delta_time;
			prod_q  <= {{TIME_W{1'b0}}, play_speed_q};
			ish_q   <= index_q;
			imod_q  <= '0;
		end else begin
			unique case (state_q)
				ST_MUL: begin
					prod_q <= {mul_sum, prod_q[SPEED_W-1:1]};
					if (cnt_q < CNT_W'(IDX_W)) begin
						imod_q <= imod_d[IDX_W-1:0];
						ish_q  <= {ish_q[IDX_W-2:0], 1'b0};
					end
				end
				ST_ADD: begin
					dvd_q  <= total;
					rem_q  <= '0;
					smod_q <= '0;
				end
				ST_DIV: begin
					rem_q  <= div_ge ? div_diff[TIME_W-1:0] : div_t[TIME_W-1:0];
					dvd_q  <= {dvd_q[TIME_W-1:0], div_ge};
					smod_q <= smod_d[IDX_W-1:0];
				end
				default: begin
					delta_q <= delta_q;
				end
			endcase
		end
	end

	sfs_sheet_pos u_sheet_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (sheet_start),
		.sheet_frame  (sheet_frame),
		.columns      (cols_eff),
		.tile_w       (tile_w_q),
		.tile_h       (tile_h_q),
		.done         (sheet_done),
		.pos          (sheet_pos)
	);

	// result register: holds until its transfer, next tick may run meanwhile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q    <= sheet_pos.x;
			out_y_q    <= sheet_pos.y;
			out_idx_q  <= index_q;
			out_jf_q   <= pulse_q;
			out_done_q <= finished_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sheet_x       = out_x_q;
	assign sheet_y       = out_y_q;
	assign frame_number  = out_idx_q;
	assign end_pulse     = out_jf_q;
	assign done_res      = out_done_q;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the sprite frame sequencer top level.
`timescale 1ns / 100ps

module tb_top;
	import sfs_pkg::*;

	// settle time after the last result
	localparam int SETTLE_CYCLES = 120;
	// cycles with no transfer at all before the run is declared hung
	localparam int STALL_LIMIT   = 4000;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_TICKS   = 75;

	typedef struct {
		logic [TIME_W-1:0] delta;
		logic              restart;
		logic              hold;
	} tick_item_t;

	typedef struct {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [IDX_W-1:0] num;
		logic             pulse;
		logic             done;
	} frame_pos_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// block inputs, all known from time zero
	logic                 cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic [TIME_W-1:0]    delta_time = '0;
	logic                 restart    = 1'b0;
	logic                 hold       = 1'b0;
	logic                 out_stall  = 1'b0;

	// block outputs
	logic                 in_stall;
	logic                 out_valid;
	logic [POS_W-1:0]     sheet_x;
	logic [POS_W-1:0]     sheet_y;
	logic [IDX_W-1:0]     frame_number;
	logic                 end_pulse;
	logic                 done_res;

	sprite_frame_sequencer_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.delta_time   (delta_time),
		.restart      (restart),
		.hold         (hold),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sheet_x      (sheet_x),
		.sheet_y      (sheet_y),
		.frame_number (frame_number),
		.end_pulse    (end_pulse),
		.done_res     (done_res)
	);

	// ------------------------------------------------------------------
	// Predictor: own copy of the registers and the clip state.
	// Register values start at their reset settings.
	// ------------------------------------------------------------------
	logic [DIM_W-1:0]   m_width     = 12'd16;
	logic [DIM_W-1:0]   m_height    = 12'd16;
	logic [SHEET_W-1:0] m_columns   = 11'd1;
	logic [IDX_W-1:0]   m_first     = '0;
	logic [LEN_W-1:0]   m_length    = 11'd1;
	logic [TIME_W-1:0]  m_period    = 32'd65536;
	logic               m_loop      = 1'b1;
	logic [SPEED_W-1:0] m_speed     = 16'd256;

	logic [IDX_W-1:0]   clip_pos    = '0;
	logic [TIME_W-1:0]  clip_time   = '0;
	logic               clip_done   = 1'b0;

	tick_item_t pending_ticks[$];
	frame_pos_t expected_frames[$];
	int         fail_count = 0;

	// calm phases run with no idling on that side
	bit         calm_in  = 1'b0;
	bit         calm_out = 1'b0;

	function automatic logic [POS_W-1:0] clamp_pos(logic [63:0] v);
		return (v > 64'd65535) ? 16'hFFFF : v[POS_W-1:0];
	endfunction

	// Apply one tick to the clip state and work out the frame it shows.
	function automatic frame_pos_t advance_clip(tick_item_t t);
		logic [63:0] scaled, period, len, total, steps, remaining, cols, sheet;
		frame_pos_t  r;
		r.pulse = 1'b0;
		if (t.restart) begin
			// restart wins over hold
			clip_pos  = '0;
			clip_time = '0;
			clip_done = 1'b0;
		end else if (!t.hold && !clip_done) begin
			scaled = (64'(t.delta) * 64'(m_speed)) >> 8;
			if (scaled > 64'hFFFF_FFFF)
				scaled = 64'hFFFF_FFFF;
			period = (m_period == '0) ? 64'd1 : 64'(m_period);
			len    = (m_length == '0) ? 64'd1 : 64'(m_length);
			if (len > 64'(MAX_FRAMES))
				len = 64'(MAX_FRAMES);
			total     = 64'(clip_time) + scaled;
			steps     = total / period;
			clip_time = 32'(total % period);
			if (steps != 0) begin
				if (m_loop) begin
					clip_pos = 10'((64'(clip_pos) + steps) % len);
				end else begin
					// an index stranded past the end finishes on the next advance
					remaining = (64'(clip_pos) < len - 1) ? len - 1 - 64'(clip_pos) : 64'd0;
					if (steps > remaining) begin
						clip_pos  = 10'(len - 1);
						clip_time = '0;
						clip_done = 1'b1;
						r.pulse   = 1'b1;
					end else begin
						clip_pos = 10'(64'(clip_pos) + steps);
					end
				end
			end
		end
		cols  = (m_columns == '0) ? 64'd1 : 64'(m_columns);
		sheet = 64'(m_first) + 64'(clip_pos);
		r.x    = clamp_pos((sheet % cols) * 64'(m_width));
		r.y    = clamp_pos((sheet / cols) * 64'(m_height));
		r.num  = clip_pos;
		r.done = clip_done;
		return r;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued ticks, holds the payload until transfer.
	// ------------------------------------------------------------------
	tick_item_t cur_tick = '{delta: '0, restart: 1'b0, hold: 1'b0};
	int         in_gap   = 0;

	always @(posedge clk) begin : drive_ticks
		logic v;
		v = in_valid;
		if (in_valid && !in_stall) begin
			// tick transferred: predict its frame now
			expected_frames.insert(expected_frames.size(), advance_clip(cur_tick));
			v = 1'b0;
		end
		if (!v) begin
			if (in_gap > 0) begin
				in_gap--;
			end else if (arst_n && pending_ticks.size() != 0) begin
				cur_tick = pending_ticks.pop_front();
				v        = 1'b1;
				in_gap   = calm_in ? 0 : gap_len();
			end
		end
		in_valid   <= v;
		delta_time <= cur_tick.delta;
		restart    <= cur_tick.restart;
		hold       <= cur_tick.hold;
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transfer against the oldest prediction
	// and stalls the output at random.
	// ------------------------------------------------------------------
	int out_hold_left = 0;

	task automatic check_field(string what, longint unsigned want, longint unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : check_frames
		frame_pos_t want;
		logic       s;
		if (out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected, expected none actual x=%0d y=%0d",
					$time, sheet_x, sheet_y);
			end else begin
				want = expected_frames.pop_front();
				check_field("sheet_x", want.x, sheet_x);
				check_field("sheet_y", want.y, sheet_y);
				check_field("frame_number", want.num, frame_number);
				check_field("end_pulse", want.pulse, end_pulse);
				check_field("done_res", want.done, done_res);
			end
		end
		if (out_hold_left > 0) begin
			s = 1'b1;
			out_hold_left--;
		end else begin
			s = 1'b0;
			if (!calm_out && $urandom_range(0, 2) == 0)
				out_hold_left = gap_len();
		end
		out_stall <= s;
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run if nothing transfers for too long.
	// ------------------------------------------------------------------
	wire moved = (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en;

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (moved)
				quiet = 0;
			else
				quiet++;
		end
		$display("[sprite_frame_sequencer_top] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// one register write; the predictor copy follows at once (block idle)
	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		case (r)
			CFG_FRAME_WIDTH:  m_width   = v[DIM_W-1:0];
			CFG_FRAME_HEIGHT: m_height  = v[DIM_W-1:0];
			CFG_SHEET_COLS:   m_columns = v[SHEET_W-1:0];
			CFG_FIRST_FRAME:  m_first   = v[IDX_W-1:0];
			CFG_CLIP_LENGTH:  m_length  = v[LEN_W-1:0];
			CFG_FRAME_PERIOD: m_period  = v[TIME_W-1:0];
			CFG_LOOP_ENABLE:  m_loop    = v[0];
			CFG_PLAY_SPEED:   m_speed   = v[SPEED_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_clip(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] cols,
			logic [CFG_W-1:0] first, logic [CFG_W-1:0] len, logic [CFG_W-1:0] period,
			logic [CFG_W-1:0] loop_on, logic [CFG_W-1:0] speed);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_SHEET_COLS, cols);
		write_reg(CFG_FIRST_FRAME, first);
		write_reg(CFG_CLIP_LENGTH, len);
		write_reg(CFG_FRAME_PERIOD, period);
		write_reg(CFG_LOOP_ENABLE, loop_on);
		write_reg(CFG_PLAY_SPEED, speed);
	endtask

	task automatic queue_tick(logic [TIME_W-1:0] d, logic rs, logic hd);
		tick_item_t t;
		t.delta   = d;
		t.restart = rs;
		t.hold    = hd;
		pending_ticks.insert(pending_ticks.size(), t);
	endtask

	// wait for every tick to transfer and every result to arrive, then let
	// the block settle before the registers may change
	task automatic drain();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || in_valid || expected_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// register value: zero, all ones, one, typical, or forced by sel;
	// now and then junk above the register width
	function automatic logic [CFG_W-1:0] rand_reg(int w, int unsigned typ, int sel);
		logic [CFG_W-1:0] ones, v;
		int               r;
		ones = (w >= CFG_W) ? '1 : ((32'd1 << w) - 1);
		r    = (sel >= 0) ? sel : $urandom_range(0, 9);
		case (r)
			0:       v = '0;
			1:       v = ones;
			2:       v = 32'd1;
			default: v = $urandom_range(1, typ) & ones;
		endcase
		if (w < CFG_W && sel < 0 && $urandom_range(0, 7) == 0)
			v |= $urandom() << w;
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int          sel, r;
		logic [63:0] span, period_eff;
		logic [31:0] d;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero and full deltas, hold, restart, restart over hold
		queue_tick(32'd0, 1'b0, 1'b0);
		queue_tick(32'd65536, 1'b0, 1'b0);
		queue_tick(32'hFFFF_FFFF, 1'b0, 1'b0);
		queue_tick(32'hFFFF_FFFF, 1'b0, 1'b1);
		queue_tick(32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
		drain();

		// zero columns, oversize length, zero period, one-shot, full speed:
		// many periods in one tick, saturated row, then saturated product finishes
		load_clip(32'd4095, 32'd4095, 32'd0, 32'd1023, 32'd2000, 32'd0, 32'd0, 32'hFFFF);
		queue_tick(32'd1, 1'b0, 1'b0);
		queue_tick(32'hFFFF_FFFF, 1'b0, 1'b0);
		queue_tick(32'd5, 1'b0, 1'b0);
		drain();

		// finished clip stays frozen after loop is set, until a restart
		write_reg(CFG_LOOP_ENABLE, 32'd1);
		queue_tick(32'd65536, 1'b0, 1'b0);
		queue_tick(32'd0, 1'b1, 1'b0);
		queue_tick(32'd3, 1'b0, 1'b0);
		drain();

		// index left beyond a shortened clip: shown as stored, then wraps
		load_clip(32'd7, 32'd5, 32'd3, 32'd2, 32'd1024, 32'd65536, 32'd1, 32'd256);
		queue_tick(32'd0, 1'b1, 1'b0);
		queue_tick(32'd600 << 16, 1'b0, 1'b0);
		drain();
		write_reg(CFG_CLIP_LENGTH, 32'd8);
		queue_tick(32'd0, 1'b0, 1'b0);
		queue_tick(32'd65536, 1'b0, 1'b0);
		drain();

		// same in one-shot mode: the next advance finishes on the last frame
		write_reg(CFG_CLIP_LENGTH, 32'd1024);
		queue_tick(32'd600 << 16, 1'b0, 1'b0);
		drain();
		write_reg(CFG_CLIP_LENGTH, 32'd8);
		write_reg(CFG_LOOP_ENABLE, 32'd0);
		queue_tick(32'd65536, 1'b0, 1'b0);
		queue_tick(32'd0, 1'b1, 1'b0);
		drain();

		// Random phases: the first two force all-ones and all-zero settings
		for (int p = 0; p < RAND_PHASES; p++) begin
			sel = (p == 0) ? 1 : (p == 1) ? 0 : -1;
			load_clip(rand_reg(DIM_W, 64, sel), rand_reg(DIM_W, 64, sel),
				rand_reg(SHEET_W, 8, sel), rand_reg(IDX_W, 64, sel),
				rand_reg(LEN_W, 12, sel), rand_reg(TIME_W, 200000, sel),
				(sel >= 0) ? 32'(sel) : 32'($urandom_range(0, 1)),
				rand_reg(SPEED_W, 1024, sel));
			calm_in  = ($urandom_range(0, 3) == 0);
			calm_out = ($urandom_range(0, 3) == 0);

			// deltas are mostly scaled to land near the frame period so
			// that frames advance, wrap and finish often
			period_eff = (m_period == '0) ? 64'd1 : 64'(m_period);
			if (m_speed == '0)
				span = 64'hFFFF_FFFF;
			else
				span = (period_eff * 64'd768) / 64'(m_speed);
			if (span > 64'hFFFF_FFFF)
				span = 64'hFFFF_FFFF;

			for (int i = 0; i < PHASE_TICKS; i++) begin
				r = $urandom_range(0, 99);
				case ($urandom_range(0, 3))
					0:       d = $urandom();
					1:       d = $urandom_range(0, 255);
					default: d = $urandom_range(0, 32'(span));
				endcase
				if (r < 5)
					queue_tick(d, 1'b1, 1'($urandom_range(0, 1)));
				else if (r < 13)
					queue_tick(d, 1'b0, 1'b1);
				else
					queue_tick(d, 1'b0, 1'b0);
			end
			drain();
		end

		if (fail_count == 0)
			$display("[sprite_frame_sequencer_top] OK");
		else
			$display("[sprite_frame_sequencer_top] ERROR");
		$finish;
	end

endmodule
